### rtl/ucal_pkg.sv
// ----------------------------------------------------------------------------
// ucal_pkg
// shared types, constants and calendar tables for the seconds-to-date core
// ----------------------------------------------------------------------------
package ucal_pkg;

  localparam int DAY_W = 16;
  localparam int DOY_W = 9;
  localparam int YEAR_W = 12;
  localparam int MONTH_W = 4;
  localparam int MDAY_W = 5;
  localparam int CYC_W = 6;

  localparam int EPOCH_YEAR = 1970;

  // 86400 = 2^7 * 675
  localparam int SEC_SHIFT = 7;
  localparam logic [25:0] DIV675_M = 26'd50903317;
  localparam int DIV675_SHIFT = 35;

  // four-year cycles counted from 1968-01-01
  localparam logic [DAY_W-1:0] EPOCH_BIAS = 16'd731;
  localparam logic [16:0] DIV1461_M = 17'd91868;
  localparam int DIV1461_SHIFT = 27;
  localparam logic [10:0] CYCLE_DAYS = 11'd1461;
  localparam logic [YEAR_W-1:0] CYCLE_BASE_YEAR = 12'd1968;
  localparam logic [10:0] YEAR1_START = 11'd366;
  localparam logic [10:0] YEAR2_START = 11'd731;
  localparam logic [10:0] YEAR3_START = 11'd1096;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [DOY_W-1:0]  doy;
    logic              leap;
  } ydoy_t;

  function automatic int days_in_span(input int span);
    int total;
    int y;
    total = 0;
    for (int i = 0; i < span; i++) begin
      y = EPOCH_YEAR + i;
      if (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) begin
        total = total + 366;
      end else begin
        total = total + 365;
      end
    end
    return total;
  endfunction

  function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [DOY_W-1:0] s;
    case (m)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd59;
      4'd3:    s = 9'd90;
      4'd4:    s = 9'd120;
      4'd5:    s = 9'd151;
      4'd6:    s = 9'd181;
      4'd7:    s = 9'd212;
      4'd8:    s = 9'd243;
      4'd9:    s = 9'd273;
      4'd10:   s = 9'd304;
      4'd11:   s = 9'd334;
      default: s = 9'd0;
    endcase
    if (leap && m >= 4'd2) begin
      s = s + 9'd1;
    end
    return s;
  endfunction

endpackage

### rtl/ucal_day_div.sv
// ----------------------------------------------------------------------------
// ucal_day_div
// two stages: seconds to whole days by reciprocal multiply, then clamp to span
// ----------------------------------------------------------------------------
module ucal_day_div #(
  parameter int YEAR_SPAN = 100
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        up_valid,
  input  logic [31:0]                 up_seconds,
  output logic                        up_stall,
  output logic                        dn_valid,
  output logic [ucal_pkg::DAY_W-1:0]  dn_days,
  input  logic                        dn_stall
);

  localparam int PROD_W = 51;
  localparam logic [ucal_pkg::DAY_W-1:0] LAST_DAY =
    ucal_pkg::DAY_W'(ucal_pkg::days_in_span(YEAR_SPAN) - 1);

  logic                       v1_r;
  logic                       v2_r;
  logic [PROD_W-1:0]          prod_r;
  logic [PROD_W-1:0]          prod_nxt;
  logic [ucal_pkg::DAY_W-1:0] days_r;
  logic [ucal_pkg::DAY_W-1:0] days_nxt;
  logic [ucal_pkg::DAY_W-1:0] quot;
  logic                       adv1;
  logic                       adv2;

  assign adv2 = !v2_r || !dn_stall;
  assign adv1 = !v1_r || adv2;
  assign up_stall = !adv1;

  assign prod_nxt = PROD_W'(up_seconds[31:ucal_pkg::SEC_SHIFT]) *
                    PROD_W'(ucal_pkg::DIV675_M);

  // clamp to december 31 of the last year, then rebase to 1968-01-01
  always_comb begin
    quot = prod_r[ucal_pkg::DIV675_SHIFT +: ucal_pkg::DAY_W];
    if (quot > LAST_DAY) begin
      days_nxt = LAST_DAY + ucal_pkg::EPOCH_BIAS;
    end else begin
      days_nxt = quot + ucal_pkg::EPOCH_BIAS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= up_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && up_valid) begin
      prod_r <= prod_nxt;
    end
    if (adv2 && v1_r) begin
      days_r <= days_nxt;
    end
  end

  assign dn_valid = v2_r;
  assign dn_days = days_r;

endmodule

### rtl/ucal_year_split.sv
// ----------------------------------------------------------------------------
// ucal_year_split
// two stages: four-year cycle by reciprocal multiply, then year and day of year
// ----------------------------------------------------------------------------
module ucal_year_split (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        up_valid,
  input  logic [ucal_pkg::DAY_W-1:0]  up_days,
  output logic                        up_stall,
  output logic                        dn_valid,
  output ucal_pkg::ydoy_t             dn_data,
  input  logic                        dn_stall
);

  localparam int PROD_W = 33;

  logic                       v1_r;
  logic                       v2_r;
  logic [ucal_pkg::DAY_W-1:0] days_r;
  logic [ucal_pkg::CYC_W-1:0] cyc_r;
  logic [PROD_W-1:0]          prod_nxt;
  ucal_pkg::ydoy_t            data_r;
  ucal_pkg::ydoy_t            data_nxt;
  logic [16:0]                cyc_days;
  logic [ucal_pkg::DAY_W-1:0] rem_wide;
  logic [10:0]                rem;
  logic [10:0]                base;
  logic [1:0]                 yoff;
  logic                       adv1;
  logic                       adv2;

  assign adv2 = !v2_r || !dn_stall;
  assign adv1 = !v1_r || adv2;
  assign up_stall = !adv1;

  assign prod_nxt = PROD_W'(up_days) * PROD_W'(ucal_pkg::DIV1461_M);

  always_comb begin
    cyc_days = 17'(cyc_r) * 17'(ucal_pkg::CYCLE_DAYS);
    rem_wide = days_r - cyc_days[ucal_pkg::DAY_W-1:0];
    rem = rem_wide[10:0];
    if (rem < ucal_pkg::YEAR1_START) begin
      yoff = 2'd0;
      base = 11'd0;
    end else if (rem < ucal_pkg::YEAR2_START) begin
      yoff = 2'd1;
      base = ucal_pkg::YEAR1_START;
    end else if (rem < ucal_pkg::YEAR3_START) begin
      yoff = 2'd2;
      base = ucal_pkg::YEAR2_START;
    end else begin
      yoff = 2'd3;
      base = ucal_pkg::YEAR3_START;
    end
    data_nxt.doy = ucal_pkg::DOY_W'(rem - base);
    data_nxt.year = ucal_pkg::CYCLE_BASE_YEAR +
                    {{(ucal_pkg::YEAR_W-ucal_pkg::CYC_W-2){1'b0}}, cyc_r, 2'b00} +
                    ucal_pkg::YEAR_W'(yoff);
    // first year of each cycle is the leap year within 1968..2099
    data_nxt.leap = (yoff == 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= up_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && up_valid) begin
      days_r <= up_days;
      cyc_r <= prod_nxt[ucal_pkg::DIV1461_SHIFT +: ucal_pkg::CYC_W];
    end
    if (adv2 && v1_r) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = v2_r;
  assign dn_data = data_r;

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (data_r.leap == (data_r.year[1:0] == 2'b00)))
    else $error("leap flag does not match year");
`endif

endmodule

### rtl/ucal_month_split.sv
// ----------------------------------------------------------------------------
// ucal_month_split
// one stage: day of year to month and day of month, output register
// ----------------------------------------------------------------------------
module ucal_month_split (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  input  ucal_pkg::ydoy_t              up_data,
  output logic                         up_stall,
  output logic                         dn_valid,
  output logic [ucal_pkg::YEAR_W-1:0]  dn_year,
  output logic [ucal_pkg::MONTH_W-1:0] dn_month,
  output logic [ucal_pkg::MDAY_W-1:0]  dn_day_of_month,
  input  logic                         dn_stall
);

  logic                         v_r;
  logic [ucal_pkg::YEAR_W-1:0]  year_r;
  logic [ucal_pkg::MONTH_W-1:0] month_r;
  logic [ucal_pkg::MONTH_W-1:0] month_nxt;
  logic [ucal_pkg::MDAY_W-1:0]  mday_r;
  logic [ucal_pkg::MDAY_W-1:0]  mday_nxt;
  logic [ucal_pkg::MONTH_W-1:0] midx;
  logic [ucal_pkg::DOY_W-1:0]   offs;
  logic                         adv;

  assign adv = !v_r || !dn_stall;
  assign up_stall = !adv;

  // month index is the count of month starts already passed
  always_comb begin
    midx = '0;
    for (int j = 1; j < 12; j++) begin
      if (up_data.doy >= ucal_pkg::month_start(ucal_pkg::MONTH_W'(j), up_data.leap)) begin
        midx = midx + 4'd1;
      end
    end
    offs = up_data.doy - ucal_pkg::month_start(midx, up_data.leap);
    month_nxt = midx + 4'd1;
    mday_nxt = ucal_pkg::MDAY_W'(offs) + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      year_r <= up_data.year;
      month_r <= month_nxt;
      mday_r <= mday_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_year = year_r;
  assign dn_month = month_r;
  assign dn_day_of_month = mday_r;

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> (month_r >= 4'd1 && month_r <= 4'd12 && mday_r >= 5'd1))
    else $error("month or day out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    (v_r && month_r == 4'd2) |-> (mday_r <= 5'd29))
    else $error("february day out of range");
`endif

endmodule

### rtl/unix_seconds_to_calendar_date_core.sv
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar_date_core
// unix seconds to gregorian year, month and day of month
// ----------------------------------------------------------------------------
// Takes one request per clock while in_stall is low and returns year, month
// and day of month for a count of seconds since 1970-01-01 00:00 UTC. There
// are five register stages, and out_valid rises once a request has passed
// through all five. Throughput is one request per cycle when neither side
// stalls. The depth is set by two constant-reciprocal multipliers
// (seconds to days, days to four-year cycles), each followed by a register,
// then year and month selection. Days past the last covered year
// (1970 + YEAR_SPAN - 1, at most 2099) clamp to December 31 of that year.
// ----------------------------------------------------------------------------
module unix_seconds_to_calendar_date_core #(
  parameter int YEAR_SPAN = 100
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [31:0]                  in_seconds_since_epoch,
  output logic                         in_stall,
  output logic                         out_valid,
  output logic [ucal_pkg::YEAR_W-1:0]  out_year,
  output logic [ucal_pkg::MONTH_W-1:0] out_month,
  output logic [ucal_pkg::MDAY_W-1:0]  out_day_of_month,
  input  logic                         out_stall
);

  logic                       days_valid;
  logic [ucal_pkg::DAY_W-1:0] days;
  logic                       days_stall;
  logic                       ydoy_valid;
  ucal_pkg::ydoy_t            ydoy;
  logic                       ydoy_stall;

  ucal_day_div #(
    .YEAR_SPAN (YEAR_SPAN)
  ) u_day_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_valid),
    .up_seconds (in_seconds_since_epoch),
    .up_stall   (in_stall),
    .dn_valid   (days_valid),
    .dn_days    (days),
    .dn_stall   (days_stall)
  );

  ucal_year_split u_year_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (days_valid),
    .up_days  (days),
    .up_stall (days_stall),
    .dn_valid (ydoy_valid),
    .dn_data  (ydoy),
    .dn_stall (ydoy_stall)
  );

  ucal_month_split u_month_split (
    .clk             (clk),
    .rst_n           (rst_n),
    .up_valid        (ydoy_valid),
    .up_data         (ydoy),
    .up_stall        (ydoy_stall),
    .dn_valid        (out_valid),
    .dn_year         (out_year),
    .dn_month        (out_month),
    .dn_day_of_month (out_day_of_month),
    .dn_stall        (out_stall)
  );

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output is free");
`endif

endmodule

### dv/unix_seconds_to_calendar_date_core_tb.sv
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar_date_core_tb
// self-checking bench for the seconds-to-calendar-date core
// ----------------------------------------------------------------------------
// Sends requests of seconds since 1970-01-01 00:00 UTC and compares every
// returned year, month and day of month against an in-bench calendar model.
// A short table covers epoch start, day and month edges, leap days
// (including the year 2000), the last covered second and the clamp past
// 2069. Random requests follow, mostly picked by day across the span, often
// on a day edge, with some past the span and some over the full 32-bit range.
// Both channels idle at random, with a long stretch of back-to-back traffic.
// ----------------------------------------------------------------------------
module unix_seconds_to_calendar_date_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int YEAR_SPAN = 100;
  localparam int unsigned SECS_PER_DAY = 60 * 60 * 24;
  localparam int unsigned SPAN_DAYS = 36525;
  localparam int unsigned LAST_COVERED_SEC = 32'd3155759999;
  localparam int RANDOM_REQUESTS = 1450;
  localparam int IDLE_PCT = 23;
  localparam int HANG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int NUM_ROWS = 24;

  typedef struct packed {
    logic [ucal_pkg::YEAR_W-1:0]  year;
    logic [ucal_pkg::MONTH_W-1:0] month;
    logic [ucal_pkg::MDAY_W-1:0]  mday;
  } cal_date_t;

  typedef struct {
    logic [31:0] secs;
    cal_date_t   date;
  } pending_t;

  typedef struct {
    logic [31:0] secs;
    bit          typed;
    int          year;
    int          month;
    int          mday;
  } row_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic [31:0]                   in_seconds_since_epoch = '0;
  logic                          in_stall;
  logic                          out_valid;
  logic [ucal_pkg::YEAR_W-1:0]   out_year;
  logic [ucal_pkg::MONTH_W-1:0]  out_month;
  logic [ucal_pkg::MDAY_W-1:0]   out_day_of_month;
  logic                          out_stall = 1'b0;

  bit                  steady = 1'b0;
  int                  mismatch_count = 0;
  int                  hang_count = 0;
  pending_t            pending_dates[$];

  int unsigned month_len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  row_t table_rows[NUM_ROWS] = '{
    '{32'd0,          1'b1, 1970, 1, 1},
    '{32'd86399,      1'b1, 1970, 1, 1},
    '{32'd86400,      1'b0, 0, 0, 0},
    '{32'd2678399,    1'b0, 0, 0, 0},
    '{32'd2678400,    1'b0, 0, 0, 0},
    '{32'd5097599,    1'b0, 0, 0, 0},
    '{32'd5097600,    1'b0, 0, 0, 0},
    '{32'd31535999,   1'b0, 0, 0, 0},
    '{32'd31536000,   1'b0, 0, 0, 0},
    '{32'd68169600,   1'b0, 0, 0, 0},
    '{32'd68256000,   1'b0, 0, 0, 0},
    '{32'd94608000,   1'b0, 0, 0, 0},
    '{32'd951782400,  1'b0, 0, 0, 0},
    '{32'd951868800,  1'b0, 0, 0, 0},
    '{32'd978220800,  1'b0, 0, 0, 0},
    '{32'd2147483647, 1'b0, 0, 0, 0},
    '{32'd2147483648, 1'b0, 0, 0, 0},
    '{32'd3124137600, 1'b0, 0, 0, 0},
    '{32'd3124224000, 1'b0, 0, 0, 0},
    '{32'hAAAAAAAA,   1'b0, 0, 0, 0},
    '{32'h55555555,   1'b0, 0, 0, 0},
    '{32'd3155759999, 1'b1, 2069, 12, 31},
    '{32'd3155760000, 1'b1, 2069, 12, 31},
    '{32'hFFFFFFFF,   1'b1, 2069, 12, 31}
  };

  unix_seconds_to_calendar_date_core #(
    .YEAR_SPAN(YEAR_SPAN)
  ) DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_seconds_since_epoch(in_seconds_since_epoch),
    .in_stall              (in_stall),
    .out_valid             (out_valid),
    .out_year              (out_year),
    .out_month             (out_month),
    .out_day_of_month      (out_day_of_month),
    .out_stall             (out_stall)
  );

  always #1 clk = ~clk;

  function automatic bit is_leap(input int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic cal_date_t predict_date(input logic [31:0] secs);
    int unsigned rem;
    int unsigned len;
    int unsigned idx;
    int unsigned mon;
    int unsigned yr;
    cal_date_t   d;
    rem = secs / SECS_PER_DAY;
    idx = 0;
    len = is_leap(ucal_pkg::EPOCH_YEAR) ? 366 : 365;
    while (idx < YEAR_SPAN && rem >= len) begin
      rem = rem - len;
      idx = idx + 1;
      len = is_leap(ucal_pkg::EPOCH_YEAR + idx) ? 366 : 365;
    end
    if (idx >= YEAR_SPAN) begin
      idx = YEAR_SPAN - 1;
      rem = (is_leap(ucal_pkg::EPOCH_YEAR + idx) ? 366 : 365) - 1;
    end
    yr = ucal_pkg::EPOCH_YEAR + idx;
    mon = 0;
    len = month_len[0];
    while (mon < 11 && rem >= len) begin
      rem = rem - len;
      mon = mon + 1;
      len = (mon == 1 && is_leap(yr)) ? 29 : month_len[mon];
    end
    d.year = yr[ucal_pkg::YEAR_W-1:0];
    d.month = ucal_pkg::MONTH_W'(mon + 1);
    d.mday = ucal_pkg::MDAY_W'(rem + 1);
    return d;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] secs,
                                 input int got, input int want);
    $display("[%0t] mismatch %s for seconds %0d: got %0d, expected %0d",
             $realtime, field, secs, got, want);
    mismatch_count++;
  endtask

  task automatic send_request(input logic [31:0] secs, input cal_date_t want);
    pending_t p;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_seconds_since_epoch <= secs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p.secs = secs;
    p.date = want;
    pending_dates.push_back(p);
  endtask

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    pending_t p;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("unexpected result, year", 32'd0, out_year, 0);
      end else begin
        p = pending_dates.pop_front();
        if (out_year !== p.date.year)
          report_mismatch("year", p.secs, out_year, p.date.year);
        if (out_month !== p.date.month)
          report_mismatch("month", p.secs, out_month, p.date.month);
        if (out_day_of_month !== p.date.mday)
          report_mismatch("day_of_month", p.secs, out_day_of_month, p.date.mday);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        hang_count <= 0;
      end else if (hang_count >= HANG_LIMIT) begin
        $display("unix_seconds_to_calendar_date_core_tb: FAIL");
        $finish;
      end else begin
        hang_count <= hang_count + 1;
      end
    end
  end

  initial begin
    cal_date_t   want;
    logic [31:0] secs;
    int unsigned kind;
    int unsigned day_idx;
    int unsigned offs;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NUM_ROWS; r++) begin
      if (table_rows[r].typed) begin
        want.year = ucal_pkg::YEAR_W'(table_rows[r].year);
        want.month = ucal_pkg::MONTH_W'(table_rows[r].month);
        want.mday = ucal_pkg::MDAY_W'(table_rows[r].mday);
      end else begin
        want = predict_date(table_rows[r].secs);
      end
      send_request(table_rows[r].secs, want);
    end

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      steady = (i >= 500 && i < 800);
      kind = $urandom_range(99);
      if (kind < 70) begin
        // land on a day edge or anywhere within a day, somewhere in the covered span
        day_idx = $urandom_range(SPAN_DAYS - 1);
        case ($urandom_range(2))
          0:       offs = 0;
          1:       offs = SECS_PER_DAY - 1;
          default: offs = $urandom_range(SECS_PER_DAY - 1);
        endcase
        secs = day_idx * SECS_PER_DAY + offs;
      end else if (kind < 85) begin
        secs = $urandom_range(LAST_COVERED_SEC);
      end else if (kind < 93) begin
        secs = $urandom_range(32'hFFFFFFFF, LAST_COVERED_SEC + 1);
      end else begin
        secs = $urandom();
      end
      send_request(secs, predict_date(secs));
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("unix_seconds_to_calendar_date_core_tb: PASS");
    end else begin
      $display("unix_seconds_to_calendar_date_core_tb: FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/ucal_pkg.sv
rtl/ucal_day_div.sv
rtl/ucal_year_split.sv
rtl/ucal_month_split.sv
rtl/unix_seconds_to_calendar_date_core.sv
dv/unix_seconds_to_calendar_date_core_tb.sv
